// File: rtl/ftp_pkg.sv
`default_nettype none

package ftp_pkg;

   // event kinds on the request channel
   localparam logic [1:0] FUNC_TICK       = 2'd0;
   localparam logic [1:0] FUNC_FRAME      = 2'd1;
   localparam logic [1:0] FUNC_UPDATE     = 2'd2;
   localparam logic [1:0] FUNC_SOFT_RESET = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_NOMINAL_PERIOD    = 2'd0;
   localparam logic [1:0] REG_PHASE_ERROR_LIMIT = 2'd1;
   localparam logic [1:0] REG_LOCK_RANGE        = 2'd2;
   localparam logic [1:0] REG_LOCK_THRESHOLD    = 2'd3;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] RST_NOMINAL_PERIOD    = 16'd2000;
   localparam logic [14:0] RST_PHASE_ERROR_LIMIT = 15'd4;
   localparam logic [15:0] RST_LOCK_RANGE        = 16'd25;
   localparam logic [15:0] RST_LOCK_THRESHOLD    = 16'd5;

   // not-computed markers and counter limits
   localparam logic [15:0] PERIOD_NONE = 16'hFFFF;
   localparam logic [15:0] PHASE_NONE  = 16'h7FFF;
   localparam logic [7:0]  COUNT_MAX   = 8'hFF;

   localparam int FILTER_FACTOR_DEF = 16;

   typedef struct packed {
      logic [15:0] nominal_period;
      logic [14:0] phase_error_limit;
      logic [15:0] lock_range;
      logic [15:0] lock_threshold;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        new_period;
      logic               period_valid;
      logic signed [15:0] phase;
      logic               is_locked;
      logic [7:0]         hits;
      logic [7:0]         misses;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/ftp_if.sv
`default_nettype none

interface ftp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] timestamp;

   modport source (output valid, output func, output timestamp, input ready);
   modport sink   (input valid, input func, input timestamp, output ready);
endinterface

interface ftp_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        new_period;
   logic               period_valid;
   logic signed [15:0] phase;
   logic               is_locked;
   logic [7:0]         hits;
   logic [7:0]         misses;

   modport source (output valid, output new_period, output period_valid, output phase,
                   output is_locked, output hits, output misses, input ready);
   modport sink   (input valid, input new_period, input period_valid, input phase,
                   input is_locked, input hits, input misses, output ready);
endinterface

interface ftp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/frame_timing_pll.sv
`default_nettype none

// Flow: a request beat lands in the input register and is evaluated from there; its
//   response (update events only) is captured in the response register as it fires.
// Throughput: one event per cycle unless an update stalls on a full response register;
//   the event logic and filter divider sit between the two registers, a single pass.
// Reset: synchronous, active high; clears all loop state, registers to defaults.
module frame_timing_pll #(
   parameter int FILTER_FACTOR = ftp_pkg::FILTER_FACTOR_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ftp_req_if.sink    req_ch,
   ftp_rsp_if.source  rsp_ch,
   ftp_csr_if.sink    csr_ch
);
   import ftp_pkg::*;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_func_ff;
   logic [15:0] in_ts_ff;

   // response stage
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;

   cfg_type     cfg;
   rsp_type     core_rsp;
   logic        is_update;
   logic        fire;

   // only an update needs room in the response register
   assign is_update   = (in_func_ff == FUNC_UPDATE);
   assign fire        = in_valid_ff && (!is_update || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready)
         in_valid_in = 1'b1;
      else if (fire)
         in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (fire && is_update)
         out_valid_in = 1'b1;
      else if (rsp_ch.ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_func_ff <= req_ch.func;
         in_ts_ff   <= req_ch.timestamp;
      end
      if (fire && is_update)
         out_ff <= core_rsp;
   end

   // config writes are always taken
   assign csr_ch.ready = 1'b1;

   ftp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   ftp_core #(
      .FILTER_FACTOR (FILTER_FACTOR)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .func      (in_func_ff),
      .timestamp (in_ts_ff),
      .cfg       (cfg),
      .result    (core_rsp)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.new_period   = out_ff.new_period;
   assign rsp_ch.period_valid = out_ff.period_valid;
   assign rsp_ch.phase        = out_ff.phase;
   assign rsp_ch.is_locked    = out_ff.is_locked;
   assign rsp_ch.hits         = out_ff.hits;
   assign rsp_ch.misses       = out_ff.misses;

endmodule

`default_nettype wire

// File: rtl/ftp_csr.sv
`default_nettype none

module ftp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [ftp_pkg::CSR_ADDR_W-1:0]    wr_index,
   input  wire logic [ftp_pkg::CSR_DATA_W-1:0]    wr_data,
   output      ftp_pkg::cfg_type                  cfg
);
   import ftp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_NOMINAL_PERIOD:    cfg_in.nominal_period    = wr_data;
            REG_PHASE_ERROR_LIMIT: cfg_in.phase_error_limit = wr_data[14:0];
            REG_LOCK_RANGE:        cfg_in.lock_range        = wr_data;
            REG_LOCK_THRESHOLD:    cfg_in.lock_threshold    = wr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_period    <= RST_NOMINAL_PERIOD;
         cfg_ff.phase_error_limit <= RST_PHASE_ERROR_LIMIT;
         cfg_ff.lock_range        <= RST_LOCK_RANGE;
         cfg_ff.lock_threshold    <= RST_LOCK_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/ftp_core.sv
`default_nettype none

module ftp_core #(
   parameter int FILTER_FACTOR = ftp_pkg::FILTER_FACTOR_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [1:0]        func,
   input  wire logic [15:0]       timestamp,
   input  wire ftp_pkg::cfg_type  cfg,
   output      ftp_pkg::rsp_type  result
);
   import ftp_pkg::*;

   // accumulator bound is 32768 * FILTER_FACTOR
   localparam int ACC_W   = $clog2(32768 * FILTER_FACTOR + 1);
   localparam int LOG_F   = $clog2(FILTER_FACTOR);
   localparam int SHIFT   = ACC_W + LOG_F;
   localparam int RECIP_W = ACC_W + 1;
   localparam longint unsigned ONE = 1;
   // exact floor division by reciprocal (round-up multiplier)
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((ONE << SHIFT) + FILTER_FACTOR - 1) / FILTER_FACTOR);
   localparam int PROD_W = ACC_W + RECIP_W;

   localparam logic [1:0] PS_INVALID = 2'd0;
   localparam logic [1:0] PS_INIT    = 2'd1;
   localparam logic [1:0] PS_LOCKED  = 2'd2;

   logic             tick_seen_ff, tick_seen_in;
   logic [15:0]      tick_time_ff, tick_time_in;
   logic             frame_seen_ff, frame_seen_in;
   logic [15:0]      frame_time_ff, frame_time_in;
   logic [1:0]       pstate_ff, pstate_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [15:0]      accq_ff, accq_in;
   logic             fvalid_ff, fvalid_in;
   logic             lock_ff, lock_in;
   logic [7:0]       hits_ff, hits_in;
   logic [7:0]       misses_ff, misses_in;

   // period window check
   logic [15:0]        est;
   logic signed [17:0] win_lo, win_hi, est_s;
   logic               in_window;

   // phase path
   logic [15:0]        diff;
   logic signed [15:0] phase;
   logic signed [15:0] half;
   logic signed [16:0] err, lim;
   logic [15:0]        pabs;
   logic [ACC_W-1:0]   acc_next;
   logic [PROD_W-1:0]  prod;
   logic [15:0]        q_next;
   logic               both_seen;

   always_comb begin
      est       = timestamp - frame_time_ff;
      est_s     = 18'(signed'({1'b0, est}));
      win_lo    = signed'(18'(cfg.nominal_period)) - signed'(18'(cfg.lock_range));
      win_hi    = signed'(18'(cfg.nominal_period)) + signed'(18'(cfg.lock_range));
      in_window = (est_s > win_lo) && (est_s < win_hi);

      diff  = tick_time_ff - frame_time_ff;
      phase = signed'(diff);
      // halve toward zero
      half  = (phase + signed'(16'(phase[15]))) >>> 1;
      lim   = signed'(17'(cfg.phase_error_limit));
      err   = 17'(half);
      if (lock_ff) begin
         if (err > lim)  err = lim;
         if (err < -lim) err = -lim;
      end
      pabs = phase[15] ? 16'(-phase) : diff;

      // first sample seeds acc = |phase| * factor
      if (fvalid_ff)
         acc_next = acc_ff + ACC_W'(pabs) - ACC_W'(accq_ff);
      else
         acc_next = ACC_W'(pabs) * ACC_W'(FILTER_FACTOR);
      prod   = PROD_W'(acc_next) * PROD_W'(RECIP);
      q_next = prod[SHIFT +: 16];
   end

   assign both_seen = tick_seen_ff && frame_seen_ff && (pstate_ff == PS_LOCKED);

   always_comb begin
      tick_seen_in  = tick_seen_ff;
      tick_time_in  = tick_time_ff;
      frame_seen_in = frame_seen_ff;
      frame_time_in = frame_time_ff;
      pstate_in     = pstate_ff;
      acc_in        = acc_ff;
      accq_in       = accq_ff;
      fvalid_in     = fvalid_ff;
      lock_in       = lock_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;

      result.new_period   = PERIOD_NONE;
      result.period_valid = 1'b0;
      result.phase        = signed'(PHASE_NONE);

      unique case (func)
         FUNC_TICK: begin
            tick_seen_in = 1'b1;
            tick_time_in = timestamp;
         end
         FUNC_FRAME: begin
            if (pstate_ff == PS_INVALID)
               pstate_in = PS_INIT;
            else if (pstate_ff == PS_INIT && in_window)
               pstate_in = PS_LOCKED;
            frame_seen_in = 1'b1;
            frame_time_in = timestamp;
         end
         FUNC_UPDATE: begin
            if (both_seen) begin
               if (hits_ff != COUNT_MAX) hits_in = hits_ff + 8'd1;
               misses_in           = 8'd0;
               result.new_period   = cfg.nominal_period - err[15:0];
               result.period_valid = 1'b1;
               result.phase        = phase;
               acc_in              = acc_next;
               accq_in             = q_next;
               fvalid_in           = 1'b1;
               if (!lock_ff && q_next < cfg.lock_threshold) lock_in = 1'b1;
            end else if (tick_seen_ff && pstate_ff == PS_LOCKED) begin
               hits_in = 8'd0;
               if (misses_ff != COUNT_MAX) misses_in = misses_ff + 8'd1;
            end
            tick_seen_in  = 1'b0;
            frame_seen_in = 1'b0;
         end
         FUNC_SOFT_RESET: begin
            tick_seen_in  = 1'b0;
            tick_time_in  = 16'd0;
            frame_seen_in = 1'b0;
            frame_time_in = 16'd0;
            fvalid_in     = 1'b0;
            lock_in       = 1'b0;
            hits_in       = 8'd0;
            misses_in     = COUNT_MAX;
         end
         default: tick_seen_in = tick_seen_ff;
      endcase

      result.is_locked = lock_in;
      result.hits      = hits_in;
      result.misses    = misses_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_seen_ff  <= 1'b0;
         tick_time_ff  <= 16'd0;
         frame_seen_ff <= 1'b0;
         frame_time_ff <= 16'd0;
         pstate_ff     <= PS_INVALID;
         fvalid_ff     <= 1'b0;
         lock_ff       <= 1'b0;
         hits_ff       <= 8'd0;
         misses_ff     <= COUNT_MAX;
      end else if (fire) begin
         tick_seen_ff  <= tick_seen_in;
         tick_time_ff  <= tick_time_in;
         frame_seen_ff <= frame_seen_in;
         frame_time_ff <= frame_time_in;
         pstate_ff     <= pstate_in;
         fvalid_ff     <= fvalid_in;
         lock_ff       <= lock_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
      end
   end

   // filter payload, qualified by fvalid_ff
   always_ff @(posedge clock) begin
      if (fire) begin
         acc_ff  <= acc_in;
         accq_ff <= accq_in;
      end
   end

endmodule

`default_nettype wire

// File: test/tb_frame_timing_pll.sv
`timescale 1ns / 100ps

module tb_frame_timing_pll;
   import ftp_pkg::*;

   localparam int FILTER_K     = FILTER_FACTOR_DEF;
   localparam int SETTLE_CYCLES = 4;        // slack after the last report for the pipeline to drain
   localparam int HOLD_CYCLES   = 300;      // long receiver hold-off for the pressure test
   localparam int DRAIN_LIMIT   = 5000;
   localparam int LIMIT_CYCLES  = 400000;

   // period checker states of the loop model
   typedef enum logic [1:0] {
      PERIOD_INVALID = 2'd0,
      PERIOD_INIT    = 2'd1,
      PERIOD_LOCKED  = 2'd2
   } period_state_type;

   logic clock = 1'b0;
   logic reset;

   ftp_req_if req_bus ();
   ftp_rsp_if rsp_bus ();
   ftp_csr_if csr_bus ();

   frame_timing_pll uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Loop model: registers and state as the block keeps them
   // ------------------------------------------------------------------
   cfg_type          loop_cfg;
   bit               tick_seen_m;
   logic [15:0]      tick_time_m;
   bit               frame_seen_m;
   logic [15:0]      frame_time_m;
   period_state_type period_state_m;
   int unsigned      filter_acc_m;
   bit               filter_valid_m;
   bit               lock_flag_m;
   logic [7:0]       hit_count_m;
   logic [7:0]       miss_count_m;

   rsp_type report_q[$];          // expected period reports, oldest first

   // run bookkeeping
   int  n_events;
   int  n_checked;
   int  n_computed;
   int  n_locked;
   int  n_cfg_writes;
   int  fail_count;
   int  cycle_count;
   bit  quiet_run;                // neither side idles
   bit  burst_send;               // sender never idles
   bit  hold_req;                 // asks the receiver for a long hold-off
   int  stall_left;
   logic [15:0] frame_mark;       // running frame timeline for well-formed traffic

   function automatic void clear_loop();
      tick_seen_m    = 1'b0;
      tick_time_m    = '0;
      frame_seen_m   = 1'b0;
      frame_time_m   = '0;
      filter_valid_m = 1'b0;
      filter_acc_m   = 0;
      lock_flag_m    = 1'b0;
      hit_count_m    = '0;
      miss_count_m   = COUNT_MAX;
   endfunction

   // Advance the loop model by one event; an update yields one report.
   function automatic void track_event(input logic [1:0] kind, input logic [15:0] stamp,
                                       output bit has_rsp, output rsp_type r);
      logic [15:0] span;
      logic [15:0] diff;
      int          est;
      int          lo;
      int          hi;
      int          ph;
      int          err;
      int          lim;
      int unsigned pabs;
      has_rsp = 1'b0;
      r       = '0;
      case (kind)
         FUNC_TICK: begin
            tick_seen_m = 1'b1;
            tick_time_m = stamp;
         end
         FUNC_FRAME: begin
            if (period_state_m == PERIOD_INVALID) begin
               period_state_m = PERIOD_INIT;
            end else if (period_state_m == PERIOD_INIT) begin
               // window bounds are unwrapped: negative lo or hi above 16 bits widens it
               span = stamp - frame_time_m;
               est  = span;
               lo   = int'(loop_cfg.nominal_period) - int'(loop_cfg.lock_range);
               hi   = int'(loop_cfg.nominal_period) + int'(loop_cfg.lock_range);
               if (est > lo && est < hi) period_state_m = PERIOD_LOCKED;
            end
            frame_seen_m = 1'b1;
            frame_time_m = stamp;
         end
         FUNC_UPDATE: begin
            has_rsp        = 1'b1;
            r.new_period   = PERIOD_NONE;
            r.period_valid = 1'b0;
            r.phase        = PHASE_NONE;
            if (tick_seen_m && frame_seen_m && period_state_m == PERIOD_LOCKED) begin
               diff = tick_time_m - frame_time_m;
               ph   = $signed(diff);
               err  = ph / 2;                  // truncates toward zero
               lim  = loop_cfg.phase_error_limit;
               pabs = (ph < 0) ? -ph : ph;
               if (hit_count_m != COUNT_MAX) hit_count_m++;
               miss_count_m = '0;
               if (lock_flag_m) begin
                  if (err > lim) err = lim;
                  if (err < -lim) err = -lim;
               end
               r.new_period   = loop_cfg.nominal_period - err[15:0];
               r.period_valid = 1'b1;
               r.phase        = diff;
               // first sample seeds the filter
               if (!filter_valid_m) begin
                  filter_acc_m   = pabs * FILTER_K;
                  filter_valid_m = 1'b1;
               end
               filter_acc_m = filter_acc_m + pabs - filter_acc_m / FILTER_K;
               if (!lock_flag_m && filter_acc_m / FILTER_K < loop_cfg.lock_threshold)
                  lock_flag_m = 1'b1;
            end else if (tick_seen_m && period_state_m == PERIOD_LOCKED) begin
               // tick but no frame: a miss
               hit_count_m = '0;
               if (miss_count_m != COUNT_MAX) miss_count_m++;
            end
            tick_seen_m  = 1'b0;
            frame_seen_m = 1'b0;
            r.is_locked  = lock_flag_m;
            r.hits       = hit_count_m;
            r.misses     = miss_count_m;
         end
         default: begin
            // soft reset keeps the period checker and the registers
            clear_loop();
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offers one event beat; valid stays high into the next call unless a gap is taken.
   task automatic send_event(input logic [1:0] kind, input logic [15:0] stamp);
      bit      has_rsp;
      rsp_type rsp;
      while (!quiet_run && !burst_send && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= kind;
      req_bus.timestamp <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_event(kind, stamp, has_rsp, rsp);
      if (has_rsp) report_q.push_back(rsp);
      n_events++;
   endtask

   // Drops valid, waits out every report, then the pipeline itself.
   task automatic settle_pipeline();
      req_bus.valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers back to back; only called with the block idle.
   task automatic set_config(input logic [15:0] period, input logic [15:0] limit,
                             input logic [15:0] range, input logic [15:0] threshold);
      logic [1:0]  idx[4];
      logic [15:0] val[4];
      idx = '{REG_NOMINAL_PERIOD, REG_PHASE_ERROR_LIMIT, REG_LOCK_RANGE, REG_LOCK_THRESHOLD};
      val = '{period, limit, range, threshold};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[i];
         csr_bus.data  <= val[i];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         case (idx[i])
            REG_NOMINAL_PERIOD:    loop_cfg.nominal_period    = val[i];
            REG_PHASE_ERROR_LIMIT: loop_cfg.phase_error_limit = val[i][14:0];
            REG_LOCK_RANGE:        loop_cfg.lock_range        = val[i];
            default:               loop_cfg.lock_threshold    = val[i];
         endcase
         n_cfg_writes++;
      end
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random ready, a quiet stretch, and one long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req) begin
         stall_left = HOLD_CYCLES;
         hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (quiet_run) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 30);
      end
   end

   // Every report beat is checked against the oldest expectation.
   always @(posedge clock) begin : check_reports
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.new_period   = rsp_bus.new_period;
         seen.period_valid = rsp_bus.period_valid;
         seen.phase        = rsp_bus.phase;
         seen.is_locked    = rsp_bus.is_locked;
         seen.hits         = rsp_bus.hits;
         seen.misses       = rsp_bus.misses;
         if (report_q.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected: period %0d valid %b phase %0d lock %b hits %0d misses %0d",
                        seen.new_period, seen.period_valid, seen.phase, seen.is_locked,
                        seen.hits, seen.misses);
            fail_count++;
         end else begin
            want = report_q.pop_front();
            n_checked++;
            if (want.period_valid) n_computed++;
            if (want.is_locked) n_locked++;
            if (seen.new_period !== want.new_period || seen.period_valid !== want.period_valid ||
                seen.phase !== want.phase || seen.is_locked !== want.is_locked ||
                seen.hits !== want.hits || seen.misses !== want.misses) begin
               if (fail_count < 10) begin
                  $display("report %0d mismatch", n_checked);
                  $display("  expected period %0d valid %b phase %0d lock %b hits %0d misses %0d",
                           want.new_period, want.period_valid, want.phase, want.is_locked,
                           want.hits, want.misses);
                  $display("  actual   period %0d valid %b phase %0d lock %b hits %0d misses %0d",
                           seen.new_period, seen.period_valid, seen.phase, seen.is_locked,
                           seen.hits, seen.misses);
               end
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("frame_timing_pll regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Updates before the period checker has locked touch nothing; a period right at
   // the window edge does not lock.
   task automatic test_update_before_lock();
      send_event(FUNC_UPDATE, 16'h0000);
      send_event(FUNC_TICK, 16'hFFFF);
      send_event(FUNC_UPDATE, 16'h0000);
      send_event(FUNC_FRAME, 16'd0);
      send_event(FUNC_FRAME, 16'd2025);     // exactly nominal + range: outside
      send_event(FUNC_TICK, 16'd2030);
      send_event(FUNC_UPDATE, 16'd2031);
      settle_pipeline();
   endtask

   // Lock the period checker through a window that spills below zero or above 16 bits.
   // The checker locks only once per run, so the seed picks which bound is exercised.
   task automatic test_period_window();
      if ($urandom_range(1) == 0) begin
         set_config(16'd10, 16'd4, 16'd100, 16'd5);       // lower bound negative
         send_event(FUNC_FRAME, 16'd1000);
         send_event(FUNC_FRAME, 16'd1005);
      end else begin
         set_config(16'd65500, 16'd4, 16'd100, 16'd5);    // upper bound above 16 bits
         send_event(FUNC_FRAME, 16'd0);
         send_event(FUNC_FRAME, 16'hFFFF);
      end
      settle_pipeline();
      set_config(RST_NOMINAL_PERIOD, 16'(RST_PHASE_ERROR_LIMIT), RST_LOCK_RANGE,
                 RST_LOCK_THRESHOLD);
   endtask

   // Phase extremes, correction clamp once locked, miss and no-tick updates.
   task automatic test_phase_cases();
      send_event(FUNC_FRAME, 16'd4049);
      send_event(FUNC_TICK, 16'd4050);
      send_event(FUNC_UPDATE, 16'd4051);    // small phase, filter seed, lock
      send_event(FUNC_FRAME, 16'd32768);
      send_event(FUNC_TICK, 16'd0);
      send_event(FUNC_UPDATE, 16'd1);       // most negative phase, clamped
      send_event(FUNC_FRAME, 16'd0);
      send_event(FUNC_TICK, 16'd32767);
      send_event(FUNC_UPDATE, 16'd2);       // most positive phase, clamped
      send_event(FUNC_TICK, 16'd5);
      send_event(FUNC_UPDATE, 16'd6);       // tick without frame: miss
      send_event(FUNC_UPDATE, 16'd7);       // no tick: nothing counted
      settle_pipeline();
   endtask

   // Soft reset drops lock and counters but keeps the period lock.
   task automatic test_soft_reset();
      send_event(FUNC_SOFT_RESET, 16'hFFFF);
      send_event(FUNC_FRAME, 16'd100);
      send_event(FUNC_TICK, 16'd90);
      send_event(FUNC_UPDATE, 16'd95);      // unclamped correction, fresh filter
      settle_pipeline();
   endtask

   // Mostly frame/tick/update cycles with random phase, plus misses, soft resets and noise.
   task automatic run_traffic(input int n_items);
      int          sent;
      int          pick;
      int          ph;
      logic [15:0] tick_at;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         frame_mark = frame_mark + loop_cfg.nominal_period + 16'(int'($urandom_range(6)) - 3);
         if (pick < 72) begin
            ph = $urandom_range(99);
            if (ph < 70)      ph = int'($urandom_range(16)) - 8;
            else if (ph < 90) ph = int'($urandom_range(600)) - 300;
            else              ph = $urandom_range(65535);
            tick_at = frame_mark + 16'(ph);
            if ($urandom_range(1)) begin
               send_event(FUNC_FRAME, frame_mark);
               send_event(FUNC_TICK, tick_at);
            end else begin
               send_event(FUNC_TICK, tick_at);
               send_event(FUNC_FRAME, frame_mark);
            end
            send_event(FUNC_UPDATE, tick_at + 16'd3);
            sent += 3;
         end else if (pick < 82) begin
            send_event(FUNC_TICK, frame_mark);
            send_event(FUNC_UPDATE, frame_mark + 16'd1);
            sent += 2;
         end else if (pick < 85) begin
            send_event(FUNC_SOFT_RESET, 16'($urandom_range(65535)));
            sent++;
         end else begin
            send_event(2'($urandom_range(3)), 16'($urandom_range(65535)));
            sent++;
         end
      end
      settle_pipeline();
   endtask

   // Random traffic over a series of register settings, extremes among them.
   task automatic test_random_traffic();
      // quiet stretch at default-like settings
      quiet_run = 1'b1;
      set_config(16'd2000, 16'd4, 16'd25, 16'd5);
      run_traffic(300);
      quiet_run = 1'b0;
      set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_traffic(200);
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_traffic(200);
      for (int i = 0; i < 4; i++) begin
         set_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)),
                    $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom_range(65535)));
         run_traffic(180);
      end
   endtask

   // Receiver holds off while the sender keeps offering beats, so the block fills
   // and back-pressures its input.
   task automatic test_backpressure();
      int          ph;
      logic [15:0] tick_at;
      set_config(16'd2000, 16'($urandom_range(32)), 16'd25, 16'd6);
      burst_send = 1'b1;
      hold_req   = 1'b1;
      for (int i = 0; i < 40; i++) begin
         frame_mark = frame_mark + loop_cfg.nominal_period;
         ph         = int'($urandom_range(20)) - 10;
         tick_at    = frame_mark + 16'(ph);
         send_event(FUNC_FRAME, frame_mark);
         send_event(FUNC_TICK, tick_at);
         send_event(FUNC_UPDATE, tick_at);
      end
      burst_send = 1'b0;
      settle_pipeline();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      int drain_wait;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_TICK;
      req_bus.timestamp = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_NOMINAL_PERIOD;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      quiet_run         = 1'b0;
      burst_send        = 1'b0;
      hold_req          = 1'b0;
      stall_left        = 0;
      frame_mark        = '0;

      loop_cfg.nominal_period    = RST_NOMINAL_PERIOD;
      loop_cfg.phase_error_limit = RST_PHASE_ERROR_LIMIT;
      loop_cfg.lock_range        = RST_LOCK_RANGE;
      loop_cfg.lock_threshold    = RST_LOCK_THRESHOLD;
      clear_loop();
      period_state_m = PERIOD_INVALID;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_update_before_lock();
      test_period_window();
      test_phase_cases();
      test_soft_reset();
      test_random_traffic();
      test_backpressure();

      // final drain, bounded
      req_bus.valid <= 1'b0;
      drain_wait = 0;
      while (report_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (report_q.size() != 0) begin
         $display("%0d expected reports never arrived", report_q.size());
         fail_count += report_q.size();
      end

      $display("%0d event beats sent, %0d register writes, %0d cycles",
               n_events, n_cfg_writes, cycle_count);
      $display("%0d reports checked: %0d with a computed period, %0d showing lock",
               n_checked, n_computed, n_locked);
      if (fail_count == 0) begin
         $display("frame_timing_pll regression: pass");
      end else begin
         $display("%0d failures", fail_count);
         $display("frame_timing_pll regression: fail");
      end
      $finish;
   end

endmodule
